// ----- rtl/core/bcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcbc_pkg: shared types and constants for the bracket/comment checker
// Character codes, kind and status encodings, stack command structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam logic [7:0] CHAR_LPAREN  = 8'h28;
	localparam logic [7:0] CHAR_RPAREN  = 8'h29;
	localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
	localparam logic [7:0] CHAR_RSQUARE = 8'h5D;
	localparam logic [7:0] CHAR_LCURLY  = 8'h7B;
	localparam logic [7:0] CHAR_RCURLY  = 8'h7D;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] END_MARKER_RST = 8'h23;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PAREN   = 2'd0;
	localparam kind_t KIND_SQUARE  = 2'd1;
	localparam kind_t KIND_CURLY   = 2'd2;
	localparam kind_t KIND_COMMENT = 2'd3;

	typedef logic [1:0] pend_t;
	localparam pend_t PEND_NONE  = 2'd0;
	localparam pend_t PEND_SLASH = 2'd1;
	localparam pend_t PEND_STAR  = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_UNEXPECTED = 3'd1;
	localparam status_t ST_MISMATCH   = 3'd2;
	localparam status_t ST_UNCLOSED   = 3'd3;
	localparam status_t ST_OVERFLOW   = 3'd4;

	typedef logic [1:0] stack_op_t;
	localparam stack_op_t OP_NOP   = 2'd0;
	localparam stack_op_t OP_PUSH  = 2'd1;
	localparam stack_op_t OP_POP   = 2'd2;
	localparam stack_op_t OP_CLEAR = 2'd3;

	typedef struct packed {
		stack_op_t op;
		kind_t     kind;
	} stack_cmd_t;

	typedef struct packed {
		logic [SP_W-1:0] depth;
		kind_t           top_kind;
	} stack_stat_t;

endpackage

// ----- rtl/core/bracket_comment_balance_checker.sv -----
// ----------------------------------------------------------------------------
// bracket_comment_balance_checker: nesting check for (), [], {} and comments
// Result is registered and valid in the cycle after the input transfer.
// Throughput: one byte per cycle unless the result is held; at most one push
// or pop per byte on the top register; entry below prefetched from RAM.
// Reset: async active low; stack empty, no pending slash/star, no error,
// end marker set to '#'. Stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_comment_balance_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       text_done,
	output logic [1:0] open_kind,
	output logic [1:0] close_kind,
	output logic [6:0] nesting_depth
);
	import bcbc_pkg::*;

	logic        accept;
	logic [7:0]  end_marker_q;
	pend_t       pend_q, pend_d, new_pend;
	status_t     err_q, err_d;
	kind_t       eok_q, eok_d, eck_q, eck_d;
	stack_cmd_t  cmd;
	stack_stat_t stat;
	logic        is_end, has_open, has_close;
	kind_t       kind_sel;
	logic [SP_W-1:0] depth_nx;

	logic        out_valid_q;
	status_t     status_nx, status_q;
	logic        done_q;
	kind_t       okind_nx, okind_q, ckind_nx, ckind_q;
	logic [SP_W-1:0] depth_out_nx, depth_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_end   = (text_byte == end_marker_q);

	// classify the byte, taking a pending slash or star into account
	always_comb begin
		has_open  = 1'b0;
		has_close = 1'b0;
		kind_sel  = KIND_PAREN;
		new_pend  = PEND_NONE;
		if (pend_q == PEND_SLASH && text_byte == CHAR_STAR) begin
			has_open = 1'b1;
			kind_sel = KIND_COMMENT;
		end else if (pend_q == PEND_STAR && text_byte == CHAR_SLASH) begin
			has_close = 1'b1;
			kind_sel  = KIND_COMMENT;
		end else begin
			unique case (text_byte)
				CHAR_SLASH:   new_pend = PEND_SLASH;
				CHAR_STAR:    new_pend = PEND_STAR;
				CHAR_LPAREN:  begin has_open = 1'b1;  kind_sel = KIND_PAREN;  end
				CHAR_LSQUARE: begin has_open = 1'b1;  kind_sel = KIND_SQUARE; end
				CHAR_LCURLY:  begin has_open = 1'b1;  kind_sel = KIND_CURLY;  end
				CHAR_RPAREN:  begin has_close = 1'b1; kind_sel = KIND_PAREN;  end
				CHAR_RSQUARE: begin has_close = 1'b1; kind_sel = KIND_SQUARE; end
				CHAR_RCURLY:  begin has_close = 1'b1; kind_sel = KIND_CURLY;  end
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.kind = kind_sel;
		pend_d   = pend_q;
		err_d    = err_q;
		eok_d    = eok_q;
		eck_d    = eck_q;
		depth_nx = stat.depth;
		if (accept) begin
			if (is_end) begin
				cmd.op = OP_CLEAR;
				pend_d = PEND_NONE;
				err_d  = ST_OK;
				eok_d  = KIND_PAREN;
				eck_d  = KIND_PAREN;
			end else if (err_q == ST_OK) begin
				// an opener or closer never leaves anything pending
				pend_d = new_pend;
				if (has_open) begin
					if (stat.depth == SP_W'(STACK_DEPTH)) begin
						err_d = ST_OVERFLOW;
						eok_d = kind_sel;
						eck_d = KIND_PAREN;
					end else begin
						cmd.op   = OP_PUSH;
						depth_nx = stat.depth + SP_W'(1);
					end
				end else if (has_close) begin
					if (stat.depth == '0) begin
						err_d = ST_UNEXPECTED;
						eok_d = KIND_PAREN;
						eck_d = kind_sel;
					end else if (stat.top_kind != kind_sel) begin
						err_d = ST_MISMATCH;
						eok_d = stat.top_kind;
						eck_d = kind_sel;
					end else begin
						cmd.op   = OP_POP;
						depth_nx = stat.depth - SP_W'(1);
					end
				end
			end
		end
	end

	// result for this byte; end marker reports state before clearing
	always_comb begin
		if (is_end) begin
			depth_out_nx = stat.depth;
			if (err_q != ST_OK) begin
				status_nx = err_q;
				okind_nx  = eok_q;
				ckind_nx  = eck_q;
			end else if (stat.depth != '0) begin
				status_nx = ST_UNCLOSED;
				okind_nx  = stat.top_kind;
				ckind_nx  = KIND_PAREN;
			end else begin
				status_nx = ST_OK;
				okind_nx  = KIND_PAREN;
				ckind_nx  = KIND_PAREN;
			end
		end else begin
			depth_out_nx = depth_nx;
			status_nx    = err_d;
			okind_nx     = eok_d;
			ckind_nx     = eck_d;
		end
	end

	bcbc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_marker_q <= END_MARKER_RST;
			pend_q       <= PEND_NONE;
			err_q        <= ST_OK;
			eok_q        <= KIND_PAREN;
			eck_q        <= KIND_PAREN;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				end_marker_q <= cfg_wr_data;
			end
			pend_q <= pend_d;
			err_q  <= err_d;
			eok_q  <= eok_d;
			eck_q  <= eck_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nx;
			done_q   <= is_end;
			okind_q  <= okind_nx;
			ckind_q  <= ckind_nx;
			depth_q  <= depth_out_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign text_done     = done_q;
	assign open_kind     = okind_q;
	assign close_kind    = ckind_q;
	assign nesting_depth = 7'(depth_q);

endmodule

// ----- rtl/core/bcbc_ram.sv -----
// ----------------------------------------------------------------------------
// bcbc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bcbc_stack.sv -----
// ----------------------------------------------------------------------------
// bcbc_stack: open-kind stack with top-of-stack register
// Top entry lives in a flop; entries below it live in RAM. The entry just
// below the top is prefetched every cycle so a pop finds it ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcbc_stack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcbc_pkg::stack_cmd_t cmd,
	output bcbc_pkg::stack_stat_t stat
);
	import bcbc_pkg::*;

	logic [SP_W-1:0]   sp_q, sp_d;
	kind_t             tos_q, tos_d;
	logic              byp_sel_q, byp_sel_d;
	kind_t             byp_q;
	kind_t             below;
	kind_t             ram_rdata;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [SP_W-1:0]   sp_wr, sp_rd;

	// entry under the top: fresh push bypasses the RAM write in flight
	assign below = byp_sel_q ? byp_q : ram_rdata;

	always_comb begin
		sp_d      = sp_q;
		tos_d     = tos_q;
		byp_sel_d = byp_sel_q;
		ram_we    = 1'b0;
		unique case (cmd.op)
			OP_PUSH: begin
				sp_d      = sp_q + SP_W'(1);
				tos_d     = cmd.kind;
				byp_sel_d = 1'b1;
				ram_we    = (sp_q != '0);
			end
			OP_POP: begin
				sp_d      = sp_q - SP_W'(1);
				tos_d     = below;
				byp_sel_d = 1'b0;
			end
			OP_CLEAR: begin
				sp_d      = '0;
				byp_sel_d = 1'b0;
			end
			default: ;
		endcase
	end

	assign sp_wr     = sp_q - SP_W'(1);
	assign sp_rd     = sp_d - SP_W'(2);
	assign ram_waddr = sp_wr[ADDR_W-1:0];
	assign ram_raddr = sp_rd[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			byp_sel_q <= 1'b0;
		end else begin
			sp_q      <= sp_d;
			byp_sel_q <= byp_sel_d;
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		if (cmd.op == OP_PUSH) begin
			byp_q <= tos_q;
		end
	end

	bcbc_ram #(
		.WIDTH (2),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tos_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign stat.depth    = sp_q;
	assign stat.top_kind = tos_q;

endmodule

// ----- rtl/core/bcbc_checker.sv -----
// ----------------------------------------------------------------------------
// bcbc_checker: port-level checks for the bracket/comment checker
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [1:0] open_kind,
	input logic [1:0] close_kind,
	input logic [6:0] nesting_depth
);
	import bcbc_pkg::*;

	// a held result blocks new input
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// every input transfer gives a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after input transfer");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nesting_depth <= 7'(STACK_DEPTH))
		else $error("nesting depth beyond stack depth");

	a_ok_no_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> open_kind == KIND_PAREN && close_kind == KIND_PAREN)
		else $error("kinds reported with ok status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(nesting_depth))
		else $error("stalled result changed");

endmodule

bind bracket_comment_balance_checker bcbc_checker u_bcbc_checker (.*);

// ----- bench/bracket_comment_balance_checker_test.sv -----
// ----------------------------------------------------------------------------
// bracket_comment_balance_checker_test: self-checking bench for the checker
// Streams short texts (balanced, damaged, pure noise, stack-deep) through the
// byte channel under random valid/ready gaps and several end-marker values.
// A scoreboard predicts the per-byte report and compares every transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_comment_balance_checker_test;

	import bcbc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 290;
	localparam int HOLD_CYCLES = 300;

	localparam logic [7:0] OPENING_TEXT [26] = '{
		CHAR_LPAREN, CHAR_LSQUARE, CHAR_LCURLY, CHAR_SLASH, CHAR_STAR,
		CHAR_STAR, CHAR_SLASH, CHAR_RCURLY, CHAR_RSQUARE, CHAR_RPAREN, END_MARKER_RST,
		CHAR_RPAREN, END_MARKER_RST,
		CHAR_LPAREN, CHAR_RSQUARE, 8'h00, END_MARKER_RST,
		CHAR_SLASH, CHAR_STAR, CHAR_SLASH, END_MARKER_RST,
		CHAR_SLASH, 8'hFF, CHAR_STAR, CHAR_LCURLY, END_MARKER_RST
	};

	typedef struct packed {
		status_t    status;
		logic       done;
		kind_t      okind;
		kind_t      ckind;
		logic [6:0] depth;
	} byte_report_t;

	// Tracks the nesting state of the text and queues the report due per byte.
	class balance_book;
		kind_t        open_stack [STACK_DEPTH];
		int           depth_now;
		pend_t        pend;
		status_t      err;
		kind_t        err_open;
		kind_t        err_close;
		logic [7:0]   end_marker;
		byte_report_t awaited[$];
		int           fail_count;

		function new();
			end_marker = END_MARKER_RST;
			fail_count = 0;
			clear_text();
		endfunction

		function void clear_text();
			depth_now = 0;
			pend      = PEND_NONE;
			err       = ST_OK;
			err_open  = KIND_PAREN;
			err_close = KIND_PAREN;
		endfunction

		function void open_sym(kind_t k);
			if (depth_now >= STACK_DEPTH) begin
				err       = ST_OVERFLOW;
				err_open  = k;
				err_close = KIND_PAREN;
			end else begin
				open_stack[depth_now] = k;
				depth_now++;
			end
		endfunction

		function void close_sym(kind_t k);
			if (depth_now == 0) begin
				err       = ST_UNEXPECTED;
				err_open  = KIND_PAREN;
				err_close = k;
			end else if (open_stack[depth_now-1] != k) begin
				err       = ST_MISMATCH;
				err_open  = open_stack[depth_now-1];
				err_close = k;
			end else begin
				depth_now--;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			byte_report_t r;
			pend_t        was;
			r = '0;
			if (b == end_marker) begin
				r.done  = 1'b1;
				r.depth = 7'(depth_now);
				if (err != ST_OK) begin
					r.status = err;
					r.okind  = err_open;
					r.ckind  = err_close;
				end else if (depth_now != 0) begin
					r.status = ST_UNCLOSED;
					r.okind  = open_stack[depth_now-1];
				end
				clear_text();
			end else begin
				if (err == ST_OK) begin
					was  = pend;
					pend = PEND_NONE;
					if (was == PEND_SLASH && b == CHAR_STAR)
						open_sym(KIND_COMMENT);
					else if (was == PEND_STAR && b == CHAR_SLASH)
						close_sym(KIND_COMMENT);
					else if (b == CHAR_SLASH)
						pend = PEND_SLASH;
					else if (b == CHAR_STAR)
						pend = PEND_STAR;
					else if (b == CHAR_LPAREN)
						open_sym(KIND_PAREN);
					else if (b == CHAR_LSQUARE)
						open_sym(KIND_SQUARE);
					else if (b == CHAR_LCURLY)
						open_sym(KIND_CURLY);
					else if (b == CHAR_RPAREN)
						close_sym(KIND_PAREN);
					else if (b == CHAR_RSQUARE)
						close_sym(KIND_SQUARE);
					else if (b == CHAR_RCURLY)
						close_sym(KIND_CURLY);
					if (err != ST_OK)
						pend = PEND_NONE;
				end
				r.status = err;
				if (err != ST_OK) begin
					r.okind = err_open;
					r.ckind = err_close;
				end
				r.depth = 7'(depth_now);
			end
			awaited = {awaited, r};
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				fail_count++;
				$display("%0t: %s mismatch, expected %0d actual %0d",
					$time, field, want, got);
			end
		endfunction

		function void check_result(status_t s, logic d, kind_t ok, kind_t ck,
				logic [6:0] dp);
			byte_report_t w;
			if (awaited.size() == 0) begin
				fail_count++;
				$display("%0t: result with no byte outstanding, expected none actual %0d",
					$time, s);
				return;
			end
			w = awaited.pop_front();
			compare("status", 8'(w.status), 8'(s));
			compare("text_done", 8'(w.done), 8'(d));
			compare("open_kind", 8'(w.okind), 8'(ok));
			compare("close_kind", 8'(w.ckind), 8'(ck));
			compare("nesting_depth", 8'(w.depth), 8'(dp));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] text_byte;
	logic       out_valid;
	logic       out_ready;
	status_t    status;
	logic       text_done;
	kind_t      open_kind;
	kind_t      close_kind;
	logic [6:0] nesting_depth;

	balance_book book = new();
	logic [7:0]  script[$];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_requests;
	int          phase_bytes;
	int          cycle_count;

	bracket_comment_balance_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.text_done    (text_done),
		.open_kind    (open_kind),
		.close_kind   (close_kind),
		.nesting_depth(nesting_depth)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result(status, text_done, open_kind, close_kind, nesting_depth);
	end

	// Result side: random back-pressure, plus a long hold whenever one is requested.
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left   = 0;
		out_ready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [7:0] opener(kind_t k);
		case (k)
			KIND_PAREN:  return CHAR_LPAREN;
			KIND_SQUARE: return CHAR_LSQUARE;
			KIND_CURLY:  return CHAR_LCURLY;
			default:     return CHAR_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] closer(kind_t k);
		case (k)
			KIND_PAREN:  return CHAR_RPAREN;
			KIND_SQUARE: return CHAR_RSQUARE;
			KIND_CURLY:  return CHAR_RCURLY;
			default:     return CHAR_STAR;
		endcase
	endfunction

	// A kind is usable when none of its delimiter bytes is the end marker.
	function automatic bit usable(kind_t k);
		if (k == KIND_COMMENT)
			return book.end_marker != CHAR_SLASH && book.end_marker != CHAR_STAR;
		return opener(k) != book.end_marker && closer(k) != book.end_marker;
	endfunction

	function automatic kind_t usable_kind();
		kind_t k;
		do
			k = kind_t'($urandom_range(3));
		while (!usable(k));
		return k;
	endfunction

	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == book.end_marker || b inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_LSQUARE,
				CHAR_RSQUARE, CHAR_LCURLY, CHAR_RCURLY, CHAR_SLASH, CHAR_STAR});
		return b;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		script = {script, b};
	endfunction

	function automatic void emit_open(kind_t k);
		if (!usable(k))
			add_byte(filler_byte());
		else if (k == KIND_COMMENT) begin
			add_byte(CHAR_SLASH);
			add_byte(CHAR_STAR);
		end else
			add_byte(opener(k));
	endfunction

	function automatic void emit_close(kind_t k);
		if (!usable(k))
			add_byte(filler_byte());
		else if (k == KIND_COMMENT) begin
			add_byte(CHAR_STAR);
			add_byte(CHAR_SLASH);
		end else
			add_byte(closer(k));
	endfunction

	// One text: mostly balanced nesting with filler, some damaged, some noise,
	// a few that fill the stack to the brim or one past it.
	function automatic void compose_text();
		int    roll;
		int    k;
		int    limit;
		bit    mangle;
		kind_t kd;
		kind_t open_q[$];
		roll = $urandom_range(99);
		if (roll < 3) begin
			limit = STACK_DEPTH + $urandom_range(1);
			repeat (limit) begin
				kd = usable_kind();
				emit_open(kd);
				open_q = {open_q, kd};
			end
			while (open_q.size() != 0) begin
				emit_close(open_q[$]);
				open_q.delete(open_q.size() - 1);
			end
		end else if (roll < 13) begin
			repeat ($urandom_range(20, 1))
				add_byte(8'($urandom_range(255)));
		end else begin
			mangle = (roll < 33);
			limit  = $urandom_range(6, 1);
			repeat ($urandom_range(30, 2)) begin
				k = $urandom_range(99);
				if (mangle && k < 6)
					emit_close(kind_t'($urandom_range(3)));
				else if (mangle && k < 10)
					add_byte(8'($urandom_range(255)));
				else if (k < 40 && open_q.size() < limit) begin
					kd = usable_kind();
					emit_open(kd);
					open_q = {open_q, kd};
				end else if (k < 70 && open_q.size() != 0) begin
					emit_close(open_q[$]);
					open_q.delete(open_q.size() - 1);
				end else
					add_byte(filler_byte());
			end
			if (!(mangle && $urandom_range(1) == 1)) begin
				while (open_q.size() != 0) begin
					emit_close(open_q[$]);
					open_q.delete(open_q.size() - 1);
				end
			end
		end
		add_byte(book.end_marker);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	// with valid still high.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		text_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
		book.note_byte(b);
		phase_bytes++;
		@(negedge clk);
	endtask

	task automatic send_script();
		while (script.size() != 0)
			send_byte(script.pop_front());
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (book.awaited.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_end_marker(input logic [7:0] v);
		wait_drained();
		repeat (3) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		book.end_marker = v;
	endtask

	initial begin
		logic [7:0] markers [6];
		markers = '{END_MARKER_RST, 8'h00, 8'hFF, CHAR_STAR, CHAR_LPAREN,
			8'($urandom_range(255))};
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 8'h00;
		in_valid      = 1'b0;
		text_byte     = 8'h00;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		cycle_count   = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 28;
				recv_idle_pct = 61;
			end else if (ph < 4) begin
				send_idle_pct = 61;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 0) begin
				foreach (OPENING_TEXT[i])
					add_byte(OPENING_TEXT[i]);
				send_script();
				wait_drained();
			end else begin
				program_end_marker(markers[ph]);
				// marker wins over a pending slash and, unless it is '(', ends an open paren
				add_byte(CHAR_LPAREN);
				add_byte(CHAR_SLASH);
				add_byte(book.end_marker);
				send_script();
			end
			if (ph == 2 || ph == 4)
				hold_requests++;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				compose_text();
				send_script();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (book.fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
